@@ rtl/ddt_pkg.sv @@
// Shared definitions for the drawdown tracker: parameter defaults and the
// sequencer state type. Used by every module in the rtl folder.
// No dependencies.
package ddt_pkg;

  localparam int SAMPLE_WIDTH_DEF  = 32;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int COUNT_WIDTH_DEF   = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ddt_state_t;

endpackage

@@ rtl/ddt_divider.sv @@
// Bit-serial restoring divider for the drawdown ratio, one quotient bit per
// cycle shifted into a quotient register. Depends on ddt_pkg for defaults.
module ddt_divider #(
  parameter int SAMPLE_WIDTH  = ddt_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = ddt_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [SAMPLE_WIDTH-1:0]    num,
  input  logic [SAMPLE_WIDTH-1:0]    den,
  output logic                       done,
  output logic [FRACTION_BITS+1:0]   quot
);

  localparam int DdBits = FRACTION_BITS + 2;
  localparam int StepW  = $clog2(DdBits);
  localparam logic [StepW-1:0] LastStep = StepW'(DdBits - 1);

  logic                      active;
  logic [StepW-1:0]          step;
  logic [SAMPLE_WIDTH:0]     rem;
  logic [SAMPLE_WIDTH+1:0]   dvs;
  logic [DdBits-1:0]         qsr;

  logic [SAMPLE_WIDTH+1:0]   den4;
  logic                      sat;
  logic [SAMPLE_WIDTH+1:0]   trial;
  logic                      fits;

  // The ratio is computed as (num * 2^(FRACTION_BITS+2)) / (4 * den) with num < 4 * den.
  assign den4  = {den, 2'b00};
  assign sat   = {2'b00, num} >= den4;
  assign trial = {rem, 1'b0};
  assign fits  = trial >= dvs;
  assign quot  = qsr;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          done <= 1'b1;
        end else begin
          active <= 1'b1;
          step   <= '0;
        end
      end else if (active) begin
        step <= step + 1'b1;
        if (step == LastStep) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, num};
      dvs <= den4;
      if (sat) begin
        qsr <= '1;
      end
    end else if (active) begin
      rem <= fits ? (trial[SAMPLE_WIDTH:0] - dvs[SAMPLE_WIDTH:0]) : trial[SAMPLE_WIDTH:0];
      qsr <= {qsr[DdBits-2:0], fits};
    end
  end

endmodule

@@ rtl/drawdown_tracker.sv @@
// Top level of the drawdown tracker: stream ports, series state, sequencer
// and output register. Depends on ddt_pkg and ddt_divider.
//
// Each input transfer carries one signed equity sample in s_tdata and the
// end-of-series flag in s_tlast. Exactly one output transfer follows each
// input: the drawdown of that sample as an unsigned ratio with FRACTION_BITS
// fraction bits and two integer bits, and, on the transfer with m_tlast set,
// the largest drawdown and the longest run of samples below the peak for the
// whole series. All series state is cleared when that result is loaded into the output register.
// The ratio is produced by a bit-serial divider, one quotient bit per cycle.
// A sample that needs a division takes the sequencer from idle through the
// divide state to done, also when the ratio saturates; a sample that needs
// no division, whose drawdown is reported as zero, goes from idle to done.
// In the done state the result is loaded into the output register, and the
// sequencer returns to idle, where the next sample can be accepted.
// The result sits in an output register, so the next sample is accepted
// while a finished result still waits. If the receiver stalls, the block
// holds its next result in the sequencer until the output register frees.
// Reset returns the sequencer to idle, clears the series state and drops m_tvalid.
module drawdown_tracker #(
  parameter int SAMPLE_WIDTH  = ddt_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRACTION_BITS = ddt_pkg::FRACTION_BITS_DEF,
  parameter int COUNT_WIDTH   = ddt_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // sample
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  // drawdown, max_drawdown, max_duration
  output logic [((2*(FRACTION_BITS+2)+COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
  output logic m_tlast
);

  localparam int DdBits = FRACTION_BITS + 2;
  localparam int OutW   = ((2*DdBits + COUNT_WIDTH + 7) / 8) * 8;

  ddt_pkg::ddt_state_t state, state_next;

  logic signed [SAMPLE_WIDTH-1:0] peak;
  logic                           started;
  logic [DdBits-1:0]              worst;
  logic [COUNT_WIDTH-1:0]         run;
  logic [COUNT_WIDTH-1:0]         longest;
  logic                           item_last;
  logic                           use_div;

  logic [DdBits-1:0]              out_dd;
  logic [DdBits-1:0]              out_mdd;
  logic [COUNT_WIDTH-1:0]         out_dur;

  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic signed [SAMPLE_WIDTH-1:0] pk;
  logic                           ge;
  logic                           need_div;
  logic [COUNT_WIDTH-1:0]         run_inc;
  logic                           accept;
  logic                           out_free;
  logic                           load_out;
  logic                           div_start;
  logic                           div_done;
  logic [DdBits-1:0]              quot;
  logic [DdBits-1:0]              dd;
  logic [DdBits-1:0]              worst_new;

  assign sample   = s_tdata[SAMPLE_WIDTH-1:0];
  assign pk       = started ? peak : sample;
  assign ge       = sample >= pk;
  assign need_div = !ge && !pk[SAMPLE_WIDTH-1] && (pk != '0);
  assign run_inc  = (run == '1) ? run : run + 1'b1;
  assign out_free = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign dd       = use_div ? quot : '0;
  assign worst_new = (dd > worst) ? dd : worst;

  ddt_divider #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (SAMPLE_WIDTH'(pk - sample)),
    .den  (pk),
    .done (div_done),
    .quot (quot)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ddt_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = need_div ? ddt_pkg::ST_DIV : ddt_pkg::ST_DONE;
        end
      end
      ddt_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = ddt_pkg::ST_DONE;
        end
      end
      ddt_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = ddt_pkg::ST_IDLE;
        end
      end
      default: state_next = ddt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ddt_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        div_start = s_tvalid && need_div;
      end
      ddt_pkg::ST_DIV: begin
      end
      ddt_pkg::ST_DONE: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ddt_pkg::ST_IDLE;
      peak    <= '0;
      started <= 1'b0;
      worst   <= '0;
      run     <= '0;
      longest <= '0;
      use_div <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        started <= 1'b1;
        use_div <= need_div;
        if (ge) begin
          peak <= sample;
          run  <= '0;
        end else begin
          peak <= pk;
          run  <= run_inc;
          if (run_inc > longest) begin
            longest <= run_inc;
          end
        end
      end else if (load_out) begin
        if (item_last) begin
          peak    <= '0;
          started <= 1'b0;
          worst   <= '0;
          run     <= '0;
          longest <= '0;
        end else begin
          worst <= worst_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_dd  <= dd;
      out_mdd <= item_last ? worst_new : '0;
      out_dur <= item_last ? longest : '0;
      m_tlast <= item_last;
    end
  end

  assign m_tdata = OutW'({out_dur, out_mdd, out_dd});

endmodule
